FILE: rtl/core/bhwb_pkg.sv
// Shared constants and types of the Bayer highlight window blend core.
package bhwb_pkg;

  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned MAX_ROWS  = 4096;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CLIP   = 2'd2;

  // One accepted sample with its window and the results it causes.
  typedef struct packed {
    logic [DATA_W-1:0] ul;
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] p;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              do_win;
    logic              win_pass;
    logic              do_lc;
    logic              do_row;
  } job_t;

endpackage

FILE: rtl/core/bhwb_queue.sv
// Short job queue between the front and back parts.
module bhwb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bhwb_pkg::job_t  push_job,
  input  logic            pop,
  output bhwb_pkg::job_t  head_job,
  output logic            full,
  output logic            empty
);

  bhwb_pkg::job_t q_r [bhwb_pkg::QDEPTH];
  logic [bhwb_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [bhwb_pkg::QPTR_W:0]   cnt_r;

  assign full     = (cnt_r == (bhwb_pkg::QPTR_W+1)'(bhwb_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: rtl/core/bhwb_front.sv
// Front part: accepts samples, tracks the raster position, keeps the line store.
module bhwb_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bhwb_pkg::DATA_W-1:0]    in_sample,
  input  logic [bhwb_pkg::DIM_W-1:0]     width_cfg,
  input  logic [bhwb_pkg::DIM_W-1:0]     height_cfg,
  output logic                           push,
  output bhwb_pkg::job_t                 push_job,
  input  logic                           q_full
);

  logic [bhwb_pkg::DATA_W-1:0] mem [bhwb_pkg::MAX_WIDTH];
  logic [bhwb_pkg::DATA_W-1:0] above_r, ul_r, left_r, p_r;
  logic [bhwb_pkg::ROW_W-1:0]  row_r, s1_row_r;
  logic [bhwb_pkg::COL_W-1:0]  col_r, s1_col_r;
  logic s1_valid_r, win_r, pass_r, lc_r, rowo_r;
  logic [bhwb_pkg::DIM_W-1:0] w_eff, h_eff;
  logic [bhwb_pkg::ROW_W-1:0] r_cur, h_last, row_nxt;
  logic [bhwb_pkg::COL_W-1:0] c_cur, w_last, col_nxt;
  logic oof, col_end, row_end, accept;

  always_comb begin
    if (width_cfg == '0) w_eff = bhwb_pkg::DIM_W'(1);
    else if (width_cfg > bhwb_pkg::DIM_W'(bhwb_pkg::MAX_WIDTH))
      w_eff = bhwb_pkg::DIM_W'(bhwb_pkg::MAX_WIDTH);
    else w_eff = width_cfg;
    if (height_cfg == '0) h_eff = bhwb_pkg::DIM_W'(1);
    else if (height_cfg > bhwb_pkg::DIM_W'(bhwb_pkg::MAX_ROWS))
      h_eff = bhwb_pkg::DIM_W'(bhwb_pkg::MAX_ROWS);
    else h_eff = height_cfg;
    w_last = bhwb_pkg::COL_W'(w_eff - 1'b1);
    h_last = bhwb_pkg::ROW_W'(h_eff - 1'b1);
    // A position left outside the frame by new settings restarts the frame.
    oof = (bhwb_pkg::DIM_W'(row_r) >= h_eff) || (bhwb_pkg::DIM_W'(col_r) >= w_eff);
    r_cur   = oof ? '0 : row_r;
    c_cur   = oof ? '0 : col_r;
    col_end = (c_cur == w_last);
    row_end = (r_cur == h_last);
    col_nxt = col_end ? '0 : c_cur + 1'b1;
    if (!col_end) row_nxt = r_cur;
    else if (row_end) row_nxt = '0;
    else row_nxt = r_cur + 1'b1;
  end

  assign push     = s1_valid_r && !q_full;
  assign in_ready = !s1_valid_r || !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      above_r    <= mem[c_cur];
      mem[c_cur] <= in_sample;
      p_r        <= in_sample;
      s1_row_r   <= r_cur;
      s1_col_r   <= c_cur;
      win_r      <= (r_cur >= bhwb_pkg::ROW_W'(2)) && (c_cur != '0);
      pass_r     <= (c_cur == bhwb_pkg::COL_W'(1));
      lc_r       <= (r_cur >= bhwb_pkg::ROW_W'(2)) && col_end;
      rowo_r     <= (r_cur == '0) || row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      row_r      <= '0;
      col_r      <= '0;
      ul_r       <= '0;
      left_r     <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        row_r      <= row_nxt;
        col_r      <= col_nxt;
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
      if (push) begin
        ul_r   <= above_r;
        left_r <= p_r;
      end
    end
  end

  always_comb begin
    push_job.ul       = ul_r;
    push_job.above    = above_r;
    push_job.left     = left_r;
    push_job.p        = p_r;
    push_job.row      = s1_row_r;
    push_job.col      = s1_col_r;
    push_job.do_win   = win_r;
    push_job.win_pass = pass_r;
    push_job.do_lc    = lc_r;
    push_job.do_row   = rowo_r;
  end

endmodule

FILE: rtl/core/bhwb_back.sv
// Back part: blend computation with a serial divider and the result register.
module bhwb_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [bhwb_pkg::DATA_W-1:0]    clip_cfg,
  input  logic                           q_empty,
  input  bhwb_pkg::job_t                 head_job,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bhwb_pkg::DATA_W-1:0]    out_value,
  output logic [bhwb_pkg::ROW_W-1:0]     out_row_index,
  output logic [bhwb_pkg::COL_W-1:0]     out_col_index,
  output logic                           out_run_last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state_r;
  bhwb_pkg::job_t job_r;
  logic win_pend_r, lc_pend_r, row_pend_r;
  logic [15:0] win_val_r;
  logic [24:0] sumlim_r;
  logic [17:0] s_r;
  logic [19:0] rem_r;
  logic [15:0] quo_r;
  logic [3:0]  cnt_r;
  logic [16:0] b_r;
  logic [34:0] prod1_r;
  logic [32:0] prod2_r;
  logic out_valid_r, out_last_r;
  logic [15:0] out_value_r;
  logic [11:0] out_row_r;
  logic [11:0] out_col_r;

  logic [15:0] c_eff;
  logic [22:0] post;
  logic [24:0] c384, num;
  logic [19:0] den;
  logic [22:0] lim0, lim1, lim2, lim3;
  logic [20:0] rem2;
  logic        qbit;
  logic [15:0] quo_nxt;
  logic [36:0] tot;
  logic [18:0] tot_q;
  logic        slot_free;
  logic        emit_go;

  function automatic logic [22:0] lim_of(input logic [15:0] v, input logic [22:0] lim);
    logic [22:0] v100;
    v100 = 23'(v) * 23'(100);
    return (v100 < lim) ? v100 : lim;
  endfunction

  always_comb begin
    c_eff = (clip_cfg == '0) ? 16'd1 : clip_cfg;
    post  = 23'(c_eff) * 23'(110);
    c384  = 25'(c_eff) * 25'(384);
    den   = 20'(c_eff) * 20'(14);
    lim0  = lim_of(job_r.ul, post);
    lim1  = lim_of(job_r.above, post);
    lim2  = lim_of(job_r.left, post);
    lim3  = lim_of(job_r.p, post);
    num   = sumlim_r - c384;
    rem2  = {rem_r, 1'b0};
    qbit  = (rem2 >= 21'(den));
    quo_nxt = {quo_r[14:0], qbit};
    tot   = 37'(prod1_r) + {2'b00, prod2_r, 2'b00} + 37'(131072);
    tot_q = tot[36:18];
    slot_free = !out_valid_r || out_ready;
    emit_go = (state_r == ST_EMIT) && slot_free && (win_pend_r || lc_pend_r || row_pend_r);
  end

  assign pop = (state_r == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          job_r      <= head_job;
          win_val_r  <= head_job.ul;
        end
      end
      ST_PREP: begin
        sumlim_r <= 25'(lim0) + 25'(lim1) + 25'(lim2) + 25'(lim3);
        s_r      <= 18'(job_r.ul) + 18'(job_r.above) + 18'(job_r.left) + 18'(job_r.p);
      end
      ST_CHECK: begin
        if (sumlim_r <= c384) begin
          b_r <= '0;
        end else if (num >= 25'(den)) begin
          b_r <= 17'h10000;
        end else begin
          rem_r <= num[19:0];
          quo_r <= '0;
          cnt_r <= '0;
        end
      end
      ST_DIV: begin
        rem_r <= qbit ? 20'(rem2 - 21'(den)) : rem2[19:0];
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 4'd15) b_r <= {1'b0, quo_nxt};
      end
      ST_MUL: begin
        prod1_r <= 35'(b_r) * 35'(s_r);
        // The window's own pixel is the upper-left sample of the job.
        prod2_r <= 33'(17'h10000 - b_r) * 33'(job_r.ul);
      end
      ST_SUM: begin
        win_val_r <= (tot_q > 19'(16'hFFFF)) ? 16'hFFFF : tot_q[15:0];
      end
      ST_EMIT: begin
        if (slot_free) begin
          priority if (win_pend_r) begin
            out_value_r <= win_val_r;
            out_row_r   <= job_r.row - 1'b1;
            out_col_r   <= job_r.col - 1'b1;
            out_last_r  <= !lc_pend_r && !row_pend_r;
          end else if (lc_pend_r) begin
            out_value_r <= job_r.above;
            out_row_r   <= job_r.row - 1'b1;
            out_col_r   <= job_r.col;
            out_last_r  <= !row_pend_r;
          end else begin
            out_value_r <= job_r.p;
            out_row_r   <= job_r.row;
            out_col_r   <= job_r.col;
            out_last_r  <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      win_pend_r  <= 1'b0;
      lc_pend_r   <= 1'b0;
      row_pend_r  <= 1'b0;
    end else begin
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            win_pend_r <= head_job.do_win;
            lc_pend_r  <= head_job.do_lc;
            row_pend_r <= head_job.do_row;
            state_r    <= (head_job.do_win && !head_job.win_pass) ? ST_PREP : ST_EMIT;
          end
        end
        ST_PREP:  state_r <= ST_CHECK;
        ST_CHECK: begin
          if (sumlim_r <= c384 || num >= 25'(den)) state_r <= ST_MUL;
          else state_r <= ST_DIV;
        end
        ST_DIV:   if (cnt_r == 4'd15) state_r <= ST_MUL;
        ST_MUL:   state_r <= ST_SUM;
        ST_SUM:   state_r <= ST_EMIT;
        ST_EMIT: begin
          if (!win_pend_r && !lc_pend_r && !row_pend_r) begin
            state_r <= ST_IDLE;
          end else if (slot_free) begin
            priority if (win_pend_r) begin
              win_pend_r <= 1'b0;
              if (!lc_pend_r && !row_pend_r) state_r <= ST_IDLE;
            end else if (lc_pend_r) begin
              lc_pend_r <= 1'b0;
              if (!row_pend_r) state_r <= ST_IDLE;
            end else begin
              row_pend_r <= 1'b0;
              state_r    <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_row_index = out_row_r;
  assign out_col_index = out_col_r;
  assign out_run_last  = out_last_r;

endmodule

FILE: rtl/core/bayer_highlight_window_blend_core.sv
// Top level of the Bayer highlight window blend core.
//
//   channel   direction  handshake            payload
//   in_       in         in_valid/in_ready    in_sample
//   out_      out        out_valid/out_ready  out_value, out_row_index,
//                                             out_col_index, out_run_last
//   cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// The front takes one sample per cycle while its four-word queue has room.
// The back takes one word at a time and emits its results in turn; a word
// whose window needs a blend first passes the prep, check, multiply and sum
// steps, and the check may start the serial divider (16 steps).
// Reset (rst_n low, synchronous) clears positions, queue and output; the
// line store holds no reset value. A stalled output holds its word while the
// queue keeps filling behind it.
module bayer_highlight_window_blend_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_value,
  output logic [11:0] out_row_index,
  output logic [11:0] out_col_index,
  output logic        out_run_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [bhwb_pkg::DIM_W-1:0]  width_r, height_r;
  logic [bhwb_pkg::DATA_W-1:0] clip_r;
  logic push, pop, q_full, q_empty;
  bhwb_pkg::job_t push_job, head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bhwb_pkg::DIM_W'(4096);
      height_r <= bhwb_pkg::DIM_W'(4096);
      clip_r   <= 16'd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bhwb_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[bhwb_pkg::DIM_W-1:0];
        bhwb_pkg::CFG_HEIGHT: height_r <= cfg_wdata[bhwb_pkg::DIM_W-1:0];
        bhwb_pkg::CFG_CLIP:   clip_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  bhwb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .push       (push),
    .push_job   (push_job),
    .q_full     (q_full)
  );

  bhwb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  bhwb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .clip_cfg      (clip_r),
    .q_empty       (q_empty),
    .head_job      (head_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_row_index (out_row_index),
    .out_col_index (out_col_index),
    .out_run_last  (out_run_last)
  );

endmodule

FILE: rtl/core/bhwb_checker.sv
// Port-level checks of the core, bound to the top level.
module bhwb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_run_last
);

  // A word that is not taken stays on offer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // Results of one sample follow each other without gaps.
  a_run_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=> out_valid)
    else $error("gap inside a run of results");

endmodule

bind bayer_highlight_window_blend_core bhwb_checker u_bhwb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_run_last (out_run_last)
);
